// ===== rtl/core/pia_mouse_pkg.sv =====
// shared types and constants for the pia mouse controller
`timescale 1ns / 1ps
package pia_mouse_pkg;

    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_DELTA  = 3'd2;
    localparam logic [2:0] MODE_BUTTON = 3'd3;
    localparam logic [2:0] MODE_BLANK  = 3'd4;

    localparam logic [1:0] REG_PORT_A = 2'd0;
    localparam logic [1:0] REG_CTRL_A = 2'd1;
    localparam logic [1:0] REG_PORT_B = 2'd2;
    localparam logic [1:0] REG_CTRL_B = 2'd3;

    localparam logic [3:0] OP_SET_MODE  = 4'h0;
    localparam logic [3:0] OP_REPORT    = 4'h1;
    localparam logic [3:0] OP_SERVE     = 4'h2;
    localparam logic [3:0] OP_RESET_POS = 4'h3;
    localparam logic [3:0] OP_SET_POS   = 4'h4;
    localparam logic [3:0] OP_DEFAULTS  = 4'h5;
    localparam logic [3:0] OP_BOUNDS    = 4'h6;
    localparam logic [3:0] OP_ORIGIN    = 4'h7;

    localparam logic [7:0]  STROBE_MASK = 8'h3E;
    localparam logic [7:0]  HS_RESET    = 8'h40;
    localparam logic [15:0] AXIS_MAX    = 16'd1023;

    // input item, packed as on tdata
    typedef struct packed {
        logic        in_vblank;
        logic        button_pressed;
        logic [15:0] delta_y;
        logic [15:0] delta_x;
        logic [7:0]  write_data;
        logic [1:0]  reg_offset;
        logic [2:0]  mode;
    } t_item;

    typedef struct packed {
        logic [2:0] rom_page;
        logic       irq_active;
        logic       irq_request;
        logic [7:0] read_data;
    } t_result;

    function automatic logic [15:0] clamp_axis(input logic [15:0] v, input logic [15:0] lo,
                                               input logic [15:0] hi);
        logic [15:0] r;
        begin
            r = v;
            if ($signed(r) < $signed(lo)) r = lo;
            if ($signed(r) > $signed(hi)) r = hi;
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/pia_mouse_core.sv =====
// register file and single-pass update of the pia and mouse controller state
`timescale 1ns / 1ps
module pia_mouse_core #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  pia_mouse_pkg::t_item    i_item,
    output pia_mouse_pkg::t_result  o_result
);
    import pia_mouse_pkg::*;

    localparam int PW = $clog2(BUFFER_DEPTH + 1);
    localparam int IW = $clog2(BUFFER_DEPTH);

    logic [7:0] r_dir_a, r_dir_b, r_out_a, r_out_b, r_in_a, r_in_b, r_ctrl_a, r_ctrl_b, r_hs;
    logic [7:0] n_dir_a, n_dir_b, n_out_a, n_out_b, n_in_a, n_in_b, n_ctrl_a, n_ctrl_b, n_hs;
    logic [7:0] r_buf [BUFFER_DEPTH];
    logic [7:0] n_buf [BUFFER_DEPTH];
    logic [PW-1:0] r_pos, n_pos;
    logic [2:0] r_tlen, n_tlen;
    logic [15:0] r_px, r_py, r_minx, r_maxx, r_miny, r_maxy;
    logic [15:0] n_px, n_py, n_minx, n_maxx, n_miny, n_maxy;
    logic [3:0] r_imode, n_imode, r_st, n_st, r_pf, n_pf;
    logic r_wasv, n_wasv;
    logic [7:0] rd;
    logic req;
    logic [7:0] diff, s, c, v;
    logic [15:0] w1, w2;

    function automatic logic [7:0] buf_at(input logic [7:0] b [BUFFER_DEPTH], input int i);
        begin
            if (i < BUFFER_DEPTH) return b[i];
            return 8'h00;
        end
    endfunction

    always_comb begin
        n_dir_a = r_dir_a; n_dir_b = r_dir_b; n_out_a = r_out_a; n_out_b = r_out_b;
        n_in_a = r_in_a; n_in_b = r_in_b; n_ctrl_a = r_ctrl_a; n_ctrl_b = r_ctrl_b;
        n_hs = r_hs; n_buf = r_buf; n_pos = r_pos; n_tlen = r_tlen;
        n_px = r_px; n_py = r_py; n_minx = r_minx; n_maxx = r_maxx;
        n_miny = r_miny; n_maxy = r_maxy; n_imode = r_imode; n_st = r_st;
        n_pf = r_pf; n_wasv = r_wasv;
        rd = 8'h00; req = 1'b0; diff = 8'h00; s = 8'h00; c = 8'h00; w1 = '0; w2 = '0;
        v = i_item.write_data;
        if (i_valid) begin
            unique case (i_item.mode)
                MODE_READ: begin
                    unique case (i_item.reg_offset)
                        REG_PORT_A: begin
                            if (r_ctrl_a[2]) begin
                                rd = (r_out_a & r_dir_a) | (r_in_a & ~r_dir_a);
                                n_ctrl_a = r_ctrl_a & 8'h3F;
                                if (!r_ctrl_b[7]) n_pf[0] = 1'b0;
                            end else rd = r_dir_a;
                        end
                        REG_CTRL_A: rd = r_ctrl_a;
                        REG_PORT_B: begin
                            if (r_ctrl_b[2]) begin
                                rd = (r_out_b & r_dir_b) | (r_in_b & ~r_dir_b);
                                n_ctrl_b = r_ctrl_b & 8'h3F;
                                if (!r_ctrl_a[7]) n_pf[0] = 1'b0;
                            end else rd = r_dir_b;
                        end
                        default: rd = r_ctrl_b;
                    endcase
                end
                MODE_WRITE: begin
                    unique case (i_item.reg_offset)
                        REG_PORT_A: begin
                            if (r_ctrl_a[2]) n_out_a = v; else n_dir_a = v;
                        end
                        REG_CTRL_A: begin
                            n_ctrl_a = {r_ctrl_a[7:6], v[5:0]};
                            if (!(r_ctrl_a[7] || r_ctrl_b[7])) n_pf[0] = 1'b0;
                        end
                        REG_PORT_B: begin
                            if (!r_ctrl_b[2]) n_dir_b = v;
                            else begin
                                n_out_b = v;
                                diff = (r_hs ^ v) & STROBE_MASK;
                                if (diff != 8'h00) begin
                                    n_hs = (r_hs & ~STROBE_MASK) | (v & STROBE_MASK);
                                    if (diff[5]) begin
                                        if (v[5]) n_hs[7] = 1'b1;
                                        else begin
                                            if (r_pos < PW'(BUFFER_DEPTH))
                                                n_buf[r_pos[IW-1:0]] = r_out_a;
                                            n_pos = r_pos + 1'b1;
                                            if (n_pos == PW'(1)) begin
                                                c = n_buf[0];
                                                unique case (c[7:4])
                                                    OP_SET_MODE: begin
                                                        n_tlen = 3'd1; n_imode = c[3:0];
                                                    end
                                                    OP_REPORT: begin
                                                        n_tlen = 3'd6;
                                                        s = {r_st[0], r_st[1], r_st[2], 5'b0};
                                                        n_st[1] = r_st[0];
                                                        n_buf[1] = r_px[7:0];
                                                        n_buf[2] = r_px[15:8];
                                                        n_buf[3] = r_py[7:0];
                                                        n_buf[4] = r_py[15:8];
                                                        n_buf[5] = s;
                                                        n_st[2] = 1'b0;
                                                    end
                                                    OP_SERVE: begin
                                                        n_tlen = 3'd2;
                                                        n_buf[1] = {4'b0, r_pf[1], r_pf[3],
                                                                    r_pf[2], 1'b0};
                                                        n_pf = 4'h0;
                                                        n_ctrl_a = n_ctrl_a & 8'h3F;
                                                    end
                                                    OP_RESET_POS: begin
                                                        n_tlen = 3'd1; n_pos = '0;
                                                        n_px = '0; n_py = '0;
                                                        n_st[2:1] = 2'b00;
                                                    end
                                                    OP_SET_POS, OP_BOUNDS: n_tlen = 3'd5;
                                                    OP_DEFAULTS: begin
                                                        n_tlen = 3'd3; n_buf[1] = 8'hFF;
                                                    end
                                                    OP_ORIGIN: begin
                                                        n_tlen = 3'd1;
                                                        n_px = '0; n_py = '0;
                                                    end
                                                    default: n_tlen = 3'd1;
                                                endcase
                                                n_in_a = n_buf[1];
                                            end
                                            if (n_pos == PW'(n_tlen) ||
                                                n_pos >= PW'(BUFFER_DEPTH)) begin
                                                c = n_buf[0];
                                                unique case (c[7:4])
                                                    OP_BOUNDS: begin
                                                        w1 = {buf_at(n_buf, 3), buf_at(n_buf, 1)};
                                                        w2 = {buf_at(n_buf, 4), buf_at(n_buf, 2)};
                                                        if (c[0]) begin
                                                            n_miny = w1; n_maxy = w2;
                                                            n_py = clamp_axis(n_py, w1, w2);
                                                        end else begin
                                                            n_minx = w1; n_maxx = w2;
                                                            n_px = clamp_axis(n_px, w1, w2);
                                                        end
                                                    end
                                                    OP_SET_POS: begin
                                                        n_px = clamp_axis({buf_at(n_buf, 2),
                                                            buf_at(n_buf, 1)}, n_minx, n_maxx);
                                                        n_py = clamp_axis({buf_at(n_buf, 4),
                                                            buf_at(n_buf, 3)}, n_miny, n_maxy);
                                                    end
                                                    OP_DEFAULTS: begin
                                                        n_minx = '0; n_maxx = AXIS_MAX;
                                                        n_miny = '0; n_maxy = AXIS_MAX;
                                                        n_px = '0; n_py = '0;
                                                    end
                                                    default: ;
                                                endcase
                                                n_pos = '0;
                                            end
                                            n_hs[7] = 1'b0;
                                        end
                                    end
                                    if (diff[4]) begin
                                        if (v[4]) n_hs[6] = 1'b0;
                                        else begin
                                            if (n_pos != '0) n_pos = n_pos + 1'b1;
                                            if (n_pos == PW'(n_tlen) ||
                                                n_pos >= PW'(BUFFER_DEPTH)) n_pos = '0;
                                            else n_in_a = n_buf[n_pos[IW-1:0]];
                                            n_hs[6] = 1'b1;
                                        end
                                    end
                                    n_in_b = n_hs;
                                end
                            end
                        end
                        default: begin
                            n_ctrl_b = {r_ctrl_b[7:6], v[5:0]};
                            if (!(r_ctrl_a[7] || r_ctrl_b[7])) n_pf[0] = 1'b0;
                        end
                    endcase
                end
                MODE_DELTA: begin
                    if (i_item.delta_x != '0 || i_item.delta_y != '0) begin
                        n_px = clamp_axis(r_px + i_item.delta_x, r_minx, r_maxx);
                        n_py = clamp_axis(r_py + i_item.delta_y, r_miny, r_maxy);
                        n_st[2] = 1'b1;
                    end
                end
                MODE_BUTTON: begin
                    if (i_item.button_pressed != r_st[0]) begin
                        n_st[1] = r_st[0];
                        n_st[0] = i_item.button_pressed;
                        n_st[3] = 1'b1;
                    end
                end
                MODE_BLANK: begin
                    if (i_item.in_vblank && !r_wasv) begin
                        if (r_imode[3]) n_pf[1] = 1'b1;
                        if (r_imode[1] && r_st[2]) n_pf[2] = 1'b1;
                        if (r_imode[2] && r_st[3]) begin
                            n_pf[3] = 1'b1; n_st[3] = 1'b0;
                        end
                        if (r_imode[0] && (n_pf[3:1] != 3'b000)) begin
                            n_pf[0] = 1'b1; n_ctrl_a[7] = 1'b1; req = 1'b1;
                        end
                    end
                    n_wasv = i_item.in_vblank;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_a <= '0; r_dir_b <= '0; r_out_a <= '0; r_out_b <= '0; r_in_a <= '0;
            r_in_b <= HS_RESET; r_ctrl_a <= '0; r_ctrl_b <= '0; r_hs <= HS_RESET;
            for (int i = 0; i < BUFFER_DEPTH; i++) r_buf[i] <= '0;
            r_pos <= '0; r_tlen <= 3'd1; r_px <= '0; r_py <= '0;
            r_minx <= '0; r_maxx <= AXIS_MAX; r_miny <= '0; r_maxy <= AXIS_MAX;
            r_imode <= '0; r_st <= '0; r_pf <= '0; r_wasv <= 1'b0;
        end else begin
            r_dir_a <= n_dir_a; r_dir_b <= n_dir_b; r_out_a <= n_out_a; r_out_b <= n_out_b;
            r_in_a <= n_in_a; r_in_b <= n_in_b; r_ctrl_a <= n_ctrl_a; r_ctrl_b <= n_ctrl_b;
            r_hs <= n_hs; r_buf <= n_buf; r_pos <= n_pos; r_tlen <= n_tlen;
            r_px <= n_px; r_py <= n_py; r_minx <= n_minx; r_maxx <= n_maxx;
            r_miny <= n_miny; r_maxy <= n_maxy; r_imode <= n_imode; r_st <= n_st;
            r_pf <= n_pf; r_wasv <= n_wasv;
        end
    end

    always_comb begin
        o_result.read_data   = rd;
        o_result.irq_request = req;
        o_result.irq_active  = n_pf[0];
        o_result.rom_page    = n_hs[3:1];
    end

endmodule

// ===== rtl/core/pia_mouse_interface_controller.sv =====
// top level: input register, controller core and output skid stage
// path: an input transaction passes the input register and the core, then the output register or skid slot
// throughput: one transaction per cycle while not stalled; the core updates all state in one pass
// stalls: input is held off while the skid slot is full or the held input has no free slot
// reset: i_rst_n synchronous active low, clears all controller state and both stages
`timescale 1ns / 1ps
module pia_mouse_interface_controller #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[2:0], reg_offset[4:3], write_data[12:5], delta_x[28:13], delta_y[44:29],
    // button_pressed[45], in_vblank[46], zero fill
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], irq_request[8], irq_active[9], rom_page[12:10], zero fill
    output logic [15:0] m_axis_tdata
);
    import pia_mouse_pkg::*;

    logic    r_in_vld;
    t_item   r_in;
    t_result core_res;
    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;

    // the held input needs a free output slot before the next transaction is taken
    assign s_axis_tready = !r_skid_vld && (!r_in_vld || !r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_vld <= 1'b0;
        else r_in_vld <= s_axis_tvalid && s_axis_tready;
        r_in <= s_axis_tdata[46:0];
    end

    pia_mouse_core #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_vld),
        .i_item   (r_in),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || m_axis_tready) begin
                if (r_skid_vld) begin
                    r_out <= r_skid;
                    r_out_vld <= 1'b1;
                    r_skid_vld <= r_in_vld;
                    r_skid <= core_res;
                end else begin
                    r_out_vld <= r_in_vld;
                    r_out <= core_res;
                end
            end else if (r_in_vld) begin
                r_skid_vld <= 1'b1;
                r_skid <= core_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

// ===== verif/pia_mouse_interface_controller_test.sv =====
// self-checking testbench for the pia mouse interface controller
`timescale 1ns / 1ps
module pia_mouse_interface_controller_test;
    import pia_mouse_pkg::*;

    localparam int DEPTH     = 8;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    pia_mouse_interface_controller #(.BUFFER_DEPTH(DEPTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the controller state
    logic [7:0]  p_dir_a, p_dir_b, p_out_a, p_out_b, p_in_a, p_in_b, p_ctrl_a, p_ctrl_b;
    logic [7:0]  p_hs;
    logic [7:0]  p_buf [DEPTH];
    int unsigned p_pos, p_len;
    logic [15:0] p_x, p_y, p_min_x, p_max_x, p_min_y, p_max_y;
    logic [3:0]  p_int_mode, p_status, p_pending;
    logic        p_was_vbl;

    t_result     pending_results[$];
    int          errors = 0;
    int          sent = 0;
    int          send_idle = 14, recv_idle = 69;
    bit          hold_recv = 1'b0;
    int          cycle = 0;

    function automatic logic [15:0] bound(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
        if ($signed(v) < $signed(lo)) v = lo;
        if ($signed(v) > $signed(hi)) v = hi;
        return v;
    endfunction

    function automatic logic [7:0] buf_rd(int unsigned i);
        return (i < DEPTH) ? p_buf[i] : 8'h00;
    endfunction

    task automatic shadow_reset();
        {p_dir_a, p_dir_b, p_out_a, p_out_b, p_in_a, p_ctrl_a, p_ctrl_b} = '0;
        p_hs = HS_RESET;
        p_in_b = HS_RESET;
        for (int i = 0; i < DEPTH; i++) p_buf[i] = '0;
        p_pos = 0;
        p_len = 1;
        {p_x, p_y, p_min_x, p_min_y} = '0;
        p_max_x = AXIS_MAX;
        p_max_y = AXIS_MAX;
        {p_int_mode, p_status, p_pending} = '0;
        p_was_vbl = 1'b0;
    endtask

    function automatic void irq_drop();
        if (!(p_ctrl_a[7] || p_ctrl_b[7])) p_pending[0] = 1'b0;
    endfunction

    function automatic void start_command();
        logic [7:0] c;
        logic [7:0] s;
        c = p_buf[0];
        s = '0;
        case (c[7:4])
            OP_SET_MODE: begin
                p_len = 1;
                p_int_mode = c[3:0];
            end
            OP_REPORT: begin
                p_len = 6;
                if (p_status[2]) s[5] = 1'b1;
                if (p_status[1]) s[6] = 1'b1;
                if (p_status[0]) begin
                    s[7] = 1'b1;
                    p_status[1] = 1'b1;
                end else p_status[1] = 1'b0;
                p_buf[1] = p_x[7:0];
                p_buf[2] = p_x[15:8];
                p_buf[3] = p_y[7:0];
                p_buf[4] = p_y[15:8];
                p_buf[5] = s;
                p_status[2] = 1'b0;
            end
            OP_SERVE: begin
                p_len = 2;
                s[1] = p_pending[2];
                s[2] = p_pending[3];
                s[3] = p_pending[1];
                p_buf[1] = s;
                p_pending = '0;
                p_ctrl_a &= 8'h3F;
            end
            OP_RESET_POS: begin
                p_len = 1;
                p_pos = 0;
                p_x = '0;
                p_y = '0;
                p_status[2:1] = 2'b00;
            end
            OP_SET_POS, OP_BOUNDS: p_len = 5;
            OP_DEFAULTS: begin
                p_len = 3;
                p_buf[1] = 8'hFF;
            end
            OP_ORIGIN: begin
                p_len = 1;
                p_x = '0;
                p_y = '0;
            end
            default: p_len = 1;
        endcase
        p_in_a = p_buf[1];
    endfunction

    function automatic void end_command();
        logic [7:0] c;
        c = p_buf[0];
        case (c[7:4])
            OP_BOUNDS: begin
                if (c[0]) begin
                    p_min_y = {buf_rd(3), buf_rd(1)};
                    p_max_y = {buf_rd(4), buf_rd(2)};
                    p_y = bound(p_y, p_min_y, p_max_y);
                end else begin
                    p_min_x = {buf_rd(3), buf_rd(1)};
                    p_max_x = {buf_rd(4), buf_rd(2)};
                    p_x = bound(p_x, p_min_x, p_max_x);
                end
            end
            OP_SET_POS: begin
                p_x = bound({buf_rd(2), buf_rd(1)}, p_min_x, p_max_x);
                p_y = bound({buf_rd(4), buf_rd(3)}, p_min_y, p_max_y);
            end
            OP_DEFAULTS: begin
                p_min_x = '0;
                p_min_y = '0;
                p_max_x = AXIS_MAX;
                p_max_y = AXIS_MAX;
                p_x = '0;
                p_y = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic void strobe_port_b(logic [7:0] v);
        logic [7:0] diff;
        diff = (p_hs ^ v) & STROBE_MASK;
        if (diff == 0) return;
        p_hs = (p_hs & ~STROBE_MASK) | (v & STROBE_MASK);
        if (diff[5]) begin
            if (v[5]) p_hs[7] = 1'b1;
            else begin
                if (p_pos < DEPTH) p_buf[p_pos] = p_out_a;
                p_pos++;
                if (p_pos == 1) start_command();
                if (p_pos == p_len || p_pos >= DEPTH) begin
                    end_command();
                    p_pos = 0;
                end
                p_hs[7] = 1'b0;
            end
        end
        if (diff[4]) begin
            if (v[4]) p_hs[6] = 1'b0;
            else begin
                if (p_pos != 0) p_pos++;
                if (p_pos == p_len || p_pos >= DEPTH) p_pos = 0;
                else p_in_a = buf_rd(p_pos);
                p_hs[6] = 1'b1;
            end
        end
        p_in_b = p_hs;
    endfunction

    function automatic t_result predict_step(t_item it);
        t_result r;
        r = '0;
        case (it.mode)
            MODE_READ: case (it.reg_offset)
                REG_PORT_A: if (p_ctrl_a[2]) begin
                    r.read_data = (p_out_a & p_dir_a) | (p_in_a & ~p_dir_a);
                    p_ctrl_a &= 8'h3F;
                    irq_drop();
                end else r.read_data = p_dir_a;
                REG_CTRL_A: r.read_data = p_ctrl_a;
                REG_PORT_B: if (p_ctrl_b[2]) begin
                    r.read_data = (p_out_b & p_dir_b) | (p_in_b & ~p_dir_b);
                    p_ctrl_b &= 8'h3F;
                    irq_drop();
                end else r.read_data = p_dir_b;
                default: r.read_data = p_ctrl_b;
            endcase
            MODE_WRITE: case (it.reg_offset)
                REG_PORT_A: if (p_ctrl_a[2]) p_out_a = it.write_data;
                            else p_dir_a = it.write_data;
                REG_CTRL_A: begin
                    p_ctrl_a = (p_ctrl_a & 8'hC0) | (it.write_data & 8'h3F);
                    irq_drop();
                end
                REG_PORT_B: if (p_ctrl_b[2]) begin
                    p_out_b = it.write_data;
                    strobe_port_b(it.write_data);
                end else p_dir_b = it.write_data;
                default: begin
                    p_ctrl_b = (p_ctrl_b & 8'hC0) | (it.write_data & 8'h3F);
                    irq_drop();
                end
            endcase
            MODE_DELTA: if (it.delta_x != 0 || it.delta_y != 0) begin
                p_x = bound(p_x + it.delta_x, p_min_x, p_max_x);
                p_y = bound(p_y + it.delta_y, p_min_y, p_max_y);
                p_status[2] = 1'b1;
            end
            MODE_BUTTON: if (it.button_pressed != p_status[0]) begin
                p_status[1] = p_status[0];
                p_status[0] = it.button_pressed;
                p_status[3] = 1'b1;
            end
            MODE_BLANK: begin
                if (it.in_vblank && !p_was_vbl) begin
                    if (p_int_mode[3]) p_pending[1] = 1'b1;
                    if (p_int_mode[1] && p_status[2]) p_pending[2] = 1'b1;
                    if (p_int_mode[2] && p_status[3]) begin
                        p_pending[3] = 1'b1;
                        p_status[3] = 1'b0;
                    end
                    if (p_int_mode[0] && (p_pending[3:1] != 0)) begin
                        p_pending[0] = 1'b1;
                        p_ctrl_a[7] = 1'b1;
                        r.irq_request = 1'b1;
                    end
                end
                p_was_vbl = it.in_vblank;
            end
            default: ;
        endcase
        r.irq_active = p_pending[0];
        r.rom_page = p_hs[3:1];
        return r;
    endfunction

    function automatic t_item mk(logic [2:0] m, logic [1:0] r, logic [7:0] d,
                                 logic [15:0] dx = 0, logic [15:0] dy = 0,
                                 logic b = 0, logic v = 0);
        t_item it;
        it.mode = m;
        it.reg_offset = r;
        it.write_data = d;
        it.delta_x = dx;
        it.delta_y = dy;
        it.button_pressed = b;
        it.in_vblank = v;
        return it;
    endfunction

    // one transaction on the input side, with random gaps before it
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= {1'b0, it};
        s_axis_tvalid <= 1'b1;
        pending_results.push_back(predict_step(it));
        sent++;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        // port a output, then strobe bit 5 high and low on port b
        send_item(mk(MODE_WRITE, REG_PORT_A, b));
        send_item(mk(MODE_WRITE, REG_PORT_B, 8'h20 | 8'($urandom_range(7)) << 1));
        send_item(mk(MODE_WRITE, REG_PORT_B, 8'($urandom_range(7)) << 1));
    endtask

    task automatic random_item();
        t_item it;
        int    k;
        k = $urandom_range(99);
        it = t_item'(47'({$urandom, $urandom}));
        if (k < 45) begin
            it.mode = ($urandom_range(1)) ? MODE_WRITE : MODE_READ;
            if (it.mode == MODE_WRITE && it.reg_offset[0]) it.write_data[2] = 1'b1;
        end else if (k < 60) begin
            it.mode = MODE_DELTA;
            if ($urandom_range(3) == 0) begin
                it.delta_x = 16'($signed(8'($urandom)));
                it.delta_y = 16'($signed(8'($urandom)));
            end else if ($urandom_range(9) == 0) begin
                it.delta_x = '0;
                it.delta_y = '0;
            end
        end else if (k < 72) it.mode = MODE_BUTTON;
        else if (k < 90) it.mode = MODE_BLANK;
        else if (k < 97) it.mode = 3'($urandom_range(4));
        else it.mode = 3'($urandom_range(7, 5));
        send_item(it);
    endtask

    // a command with random content, usually sent at its full length
    task automatic random_command();
        logic [7:0] c;
        int         n;
        c = {4'($urandom_range(15)), 4'($urandom)};
        if ($urandom_range(3) == 0) c[7:4] = OP_SET_MODE;
        n = (c[7:4] == OP_SET_POS || c[7:4] == OP_BOUNDS) ? 5 :
            (c[7:4] == OP_DEFAULTS) ? 3 : 1;
        if ($urandom_range(9) == 0) n = $urandom_range(1, 10);
        send_byte(c);
        for (int i = 1; i < n; i++) begin
            if ((c[7:4] == OP_BOUNDS) && i < 5 && $urandom_range(1))
                send_byte((i < 3) ? 8'($urandom_range(255)) : ((i == 3) ? 8'h00 : 8'h03));
            else send_byte(8'($urandom));
        end
        // read back response bytes through port a with bit 4 strobes
        for (int i = 0; i < $urandom_range(6); i++) begin
            send_item(mk(MODE_WRITE, REG_PORT_B, 8'h10));
            send_item(mk(MODE_WRITE, REG_PORT_B, 8'h00));
            send_item(mk(MODE_READ, REG_PORT_A, 8'h00));
        end
    endtask

    typedef struct {
        t_item   item;
        bit      known;
        t_result result;
    } t_row;

    t_row rows [$];

    initial begin
        t_result r;
        int      phase_end;
        shadow_reset();
        rows = '{
            '{mk(MODE_READ, REG_CTRL_A, 8'h00), 1, t_result'({3'd0, 1'b0, 1'b0, 8'h00})},
            '{mk(MODE_READ, REG_PORT_B, 8'h00), 1, t_result'({3'd0, 1'b0, 1'b0, 8'h00})},
            '{mk(3'd7, REG_CTRL_B, 8'hFF), 1, t_result'({3'd0, 1'b0, 1'b0, 8'h00})},
            '{mk(MODE_WRITE, REG_PORT_A, 8'hFF), 0, '0},
            '{mk(MODE_WRITE, REG_CTRL_A, 8'hFF), 0, '0},
            '{mk(MODE_WRITE, REG_CTRL_B, 8'hFF), 0, '0},
            '{mk(MODE_READ, REG_CTRL_B, 8'h00), 1, t_result'({3'd0, 1'b0, 1'b0, 8'h3F})},
            '{mk(MODE_READ, REG_PORT_B, 8'h00), 1, t_result'({3'd0, 1'b0, 1'b0, 8'h40})},
            '{mk(MODE_WRITE, REG_PORT_A, 8'h0F), 0, '0},
            '{mk(MODE_WRITE, REG_PORT_B, 8'h20), 0, '0},
            '{mk(MODE_WRITE, REG_PORT_B, 8'h0E), 0, '0},
            '{mk(MODE_DELTA, 0, 0, 16'h7FFF, 16'h8000), 0, '0},
            '{mk(MODE_DELTA, 0, 0, 16'h0000, 16'h0000), 0, '0},
            '{mk(MODE_DELTA, 0, 0, 16'hFFFF, 16'h0200), 0, '0},
            '{mk(MODE_BUTTON, 0, 0, 0, 0, 1'b1), 0, '0},
            '{mk(MODE_BLANK, 0, 0, 0, 0, 0, 1'b1), 0, '0},
            '{mk(MODE_READ, REG_PORT_A, 8'h00), 0, '0},
            '{mk(MODE_BLANK, 0, 0, 0, 0, 0, 1'b0), 0, '0},
            '{mk(MODE_WRITE, REG_PORT_A, 8'hC5), 0, '0},
            '{mk(MODE_WRITE, REG_PORT_B, 8'h20), 0, '0},
            '{mk(MODE_WRITE, REG_PORT_B, 8'h00), 0, '0},
            '{mk(3'd5, REG_PORT_A, 8'h00), 0, '0},
            '{mk(MODE_READ, REG_CTRL_A, 8'h00), 0, '0}
        };
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[i]) begin
            send_item(rows[i].item);
            if (rows[i].known) begin
                r = pending_results.pop_back();
                pending_results.push_back(rows[i].result);
            end
        end
        wait_drain();
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle = 69;
                recv_idle = 14;
            end else if (phase == 2) begin
                send_idle = 0;
                recv_idle = 0;
                hold_recv = 1'b1;
            end
            phase_end = sent + 200;
            while (sent < phase_end) begin
                if ($urandom_range(2) == 0) random_command();
                else random_item();
            end
            wait_drain();
        end
        for (int n = 0; n < 4; n++) begin
            send_byte({OP_BOUNDS, 4'($urandom_range(1))});
            send_byte(8'hFF); send_byte(8'h00); send_byte(8'h7F); send_byte(8'h80);
            random_item();
        end
        wait_drain();
        if (errors == 0) $display("** pia_mouse_interface_controller: PASSED **");
        else $display("** pia_mouse_interface_controller: FAILED **");
        $finish;
    end

    // receiver: random stalls and one long hold-off
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_recv && hold == 0) begin
                hold_recv = 1'b0;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[12:0]);
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data) begin
                    $error("read_data expected %h actual %h", want.read_data, got.read_data);
                    errors++;
                end
                if (got.irq_request !== want.irq_request) begin
                    $error("irq_request expected %b actual %b",
                           want.irq_request, got.irq_request);
                    errors++;
                end
                if (got.irq_active !== want.irq_active) begin
                    $error("irq_active expected %b actual %b", want.irq_active, got.irq_active);
                    errors++;
                end
                if (got.rom_page !== want.rom_page) begin
                    $error("rom_page expected %d actual %d", want.rom_page, got.rom_page);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle++;
        if (cycle > MAX_CYCLE) begin
            $display("** pia_mouse_interface_controller: FAILED **");
            $finish;
        end
    end
endmodule
